/* rtl/scl_pkg.sv */
// scl_pkg: shared types and constants for the serial command line classifier
// covers command table, event codes, trim phase encoding and result struct
// no dependencies
`timescale 1ns / 1ps

package scl_pkg;

    // byte codes
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // command table
    localparam int NUM_CMDS  = 7;
    localparam int CMD_CHARS = 5;
    localparam int POS_W     = 3;

    localparam logic [0:NUM_CMDS-1][0:CMD_CHARS-1][7:0] CMD_TEXT = '{
        '{8'h77, 8'h00, 8'h00, 8'h00, 8'h00},   // w
        '{8'h73, 8'h00, 8'h00, 8'h00, 8'h00},   // s
        '{8'h65, 8'h00, 8'h00, 8'h00, 8'h00},   // e
        '{8'h71, 8'h00, 8'h00, 8'h00, 8'h00},   // q
        '{8'h77, 8'h69, 8'h66, 8'h69, 8'h00},   // wifi
        '{8'h63, 8'h6C, 8'h65, 8'h61, 8'h72},   // clear
        '{8'h68, 8'h65, 8'h6C, 8'h70, 8'h00}    // help
    };

    localparam logic [0:NUM_CMDS-1][POS_W-1:0] CMD_LEN = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd5, 3'd4
    };

    localparam logic [POS_W-1:0] POS_MAX = 3'd7;

    // event codes
    localparam int EV_W = 3;
    localparam logic [EV_W-1:0] EV_TEXT = 3'd7;

    // trim phase, one-hot
    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_WORD = 3'b010,
        PH_TAIL = 3'b100
    } trim_phase_t;

    // result handed from the line tracker to the output register
    typedef struct packed {
        logic            valid;
        logic [EV_W-1:0] code;
    } scl_result_t;

endpackage

/* rtl/scl_char_match.sv */
// scl_char_match: folds one byte to lower case and compares it against the
// command table at the current word position
// depends on scl_pkg
`timescale 1ns / 1ps

module scl_char_match (
    input  logic [7:0]                      rx_byte,
    input  logic [scl_pkg::POS_W-1:0]       word_position,
    output logic [scl_pkg::NUM_CMDS-1:0]    keep_mask
);

    logic [7:0] folded;

    // ascii upper case to lower case only
    always_comb begin
        if (rx_byte >= scl_pkg::CHAR_UC_A && rx_byte <= scl_pkg::CHAR_UC_Z) begin
            folded = rx_byte + scl_pkg::CASE_OFFSET;
        end else begin
            folded = rx_byte;
        end
    end

    // per command compare at the current position
    always_comb begin
        keep_mask = '0;
        for (int k = 0; k < scl_pkg::NUM_CMDS; k++) begin
            for (int j = 0; j < scl_pkg::CMD_CHARS; j++) begin
                if (word_position == scl_pkg::POS_W'(j)
                        && scl_pkg::POS_W'(j) < scl_pkg::CMD_LEN[k]
                        && scl_pkg::CMD_TEXT[k][j] == folded) begin
                    keep_mask[k] = 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/scl_line_tracker.sv */
// scl_line_tracker: per-line state (kept count, trim phase, word position,
// candidate mask) and end-of-line classification
// depends on scl_pkg and scl_char_match
`timescale 1ns / 1ps

module scl_line_tracker #(
    parameter int MAX_LINE = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           rx_byte,
    output scl_pkg::scl_result_t result
);

    localparam int KW = $clog2(MAX_LINE + 1);
    localparam logic [KW-1:0] KEPT_LIMIT = KW'(MAX_LINE);

    logic [KW-1:0]                    kept_count_reg, kept_count_next;
    scl_pkg::trim_phase_t             trim_phase_reg, trim_phase_next;
    logic [scl_pkg::POS_W-1:0]        word_position_reg, word_position_next;
    logic [scl_pkg::NUM_CMDS-1:0]     candidate_mask_reg, candidate_mask_next;
    logic [scl_pkg::NUM_CMDS-1:0]     keep_mask;
    logic                             is_eol;
    logic                             is_blank;
    logic [scl_pkg::EV_W-1:0]         end_code;

    scl_char_match u_char_match (
        .rx_byte       (rx_byte),
        .word_position (word_position_reg),
        .keep_mask     (keep_mask)
    );

    assign is_eol   = (rx_byte == scl_pkg::CHAR_LF) || (rx_byte == scl_pkg::CHAR_CR);
    assign is_blank = (rx_byte == scl_pkg::CHAR_SPACE) || (rx_byte == scl_pkg::CHAR_TAB)
                   || (rx_byte == scl_pkg::CHAR_VT) || (rx_byte == scl_pkg::CHAR_FF);

    // lowest command still matching with full length wins
    always_comb begin
        end_code = scl_pkg::EV_TEXT;
        for (int k = scl_pkg::NUM_CMDS - 1; k >= 0; k--) begin
            if (candidate_mask_reg[k] && word_position_reg == scl_pkg::CMD_LEN[k]) begin
                end_code = scl_pkg::EV_W'(k);
            end
        end
    end

    // next line state
    always_comb begin
        kept_count_next     = kept_count_reg;
        trim_phase_next     = trim_phase_reg;
        word_position_next  = word_position_reg;
        candidate_mask_next = candidate_mask_reg;
        result.valid        = 1'b0;
        result.code         = end_code;
        if (step_en) begin
            priority if (is_eol) begin
                // end of line, empty lines are ignored
                if (kept_count_reg != '0) begin
                    result.valid        = 1'b1;
                    kept_count_next     = '0;
                    trim_phase_next     = scl_pkg::PH_LEAD;
                    word_position_next  = '0;
                    candidate_mask_next = '1;
                end
            end else if (kept_count_reg < KEPT_LIMIT) begin
                kept_count_next = kept_count_reg + 1'b1;
                if (is_blank) begin
                    if (trim_phase_reg == scl_pkg::PH_WORD) begin
                        trim_phase_next = scl_pkg::PH_TAIL;
                    end
                end else begin
                    // text after trailing whitespace can never match
                    if (trim_phase_reg == scl_pkg::PH_TAIL) begin
                        candidate_mask_next = '0;
                    end else begin
                        candidate_mask_next = candidate_mask_reg & keep_mask;
                    end
                    trim_phase_next = scl_pkg::PH_WORD;
                    if (word_position_reg != scl_pkg::POS_MAX) begin
                        word_position_next = word_position_reg + 1'b1;
                    end
                end
            end else begin
                // bytes beyond the line limit are dropped
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_count_reg     <= '0;
            trim_phase_reg     <= scl_pkg::PH_LEAD;
            word_position_reg  <= '0;
            candidate_mask_reg <= '1;
        end else begin
            kept_count_reg     <= kept_count_next;
            trim_phase_reg     <= trim_phase_next;
            word_position_reg  <= word_position_next;
            candidate_mask_reg <= candidate_mask_next;
        end
    end

endmodule

/* rtl/serial_command_line_classifier.sv */
// serial_command_line_classifier: a byte passes from the input request through
// the input register, then the result register, to the result request
// throughput: one byte per cycle while the result register is free or draining,
// at most one result per byte, set by the line state update in scl_line_tracker
// reset: synchronous active-low aresetn empties both registers and starts a
// fresh line; no clearing pass
`timescale 1ns / 1ps

module serial_command_line_classifier #(
    parameter int MAX_LINE = 63
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] event_code, [7:3] zero
);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     out_valid_reg;
    logic [scl_pkg::EV_W-1:0] out_code_reg;
    logic                     advance;
    logic                     step_en;
    scl_pkg::scl_result_t     result;

    // the processing stage moves when the result register is free or draining
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    scl_line_tracker #(
        .MAX_LINE (MAX_LINE)
    ) u_line_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_en && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && result.valid) begin
            out_code_reg <= result.code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8 - scl_pkg::EV_W){1'b0}}, out_code_reg};

`ifndef SYNTHESIS
    // input side stalls only when both registers are full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // a new result request always comes from a byte held in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a pending byte");

    // a waiting result keeps its code until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_code_reg))
        else $error("pending result code changed");
`endif

endmodule

/* tb/sv/tb_serial_command_line_classifier.sv */
// tb_serial_command_line_classifier: self-checking bench for the serial command line classifier
// streams directed and random byte lines, predicts each event code and checks it on the result side
// depends on scl_pkg and serial_command_line_classifier
`timescale 1ns / 1ps

module tb_serial_command_line_classifier;

    localparam int LINE_KEEP    = 63;
    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_PCT     = 24;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 200;
    localparam int LIMIT_NS     = 12 * 300_000;

    // event codes as they leave the block
    typedef enum logic [scl_pkg::EV_W-1:0] {
        EVT_UP, EVT_DOWN, EVT_SELECT, EVT_BACK, EVT_WIFI, EVT_CLEAR, EVT_HELP, EVT_TEXT
    } line_event_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [2:0] event_code, [7:3] zero

    logic [7:0]  pending_bytes[$];
    line_event_t events_due[$];
    int          sent_cnt = 0;
    int          fails = 0;
    int          hold_left = 0;
    bit          hold_used = 1'b0;
    wire         calm = (sent_cnt >= 150) && (sent_cnt < 330);

    // line state of the classifier as predicted here
    int                     line_len;
    scl_pkg::trim_phase_t   phase;
    logic [2:0]             word_pos;
    logic [6:0]             cmd_mask;

    serial_command_line_classifier #(.MAX_LINE(LINE_KEEP)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic start_line();
        line_len = 0;
        phase    = scl_pkg::PH_LEAD;
        word_pos = '0;
        cmd_mask = '1;
    endtask

    // advance the line state by one byte, queue an event code at a line end
    task automatic classify_byte(input logic [7:0] rx);
        logic [7:0]  lc;
        logic [6:0]  still;
        line_event_t code;
        if (rx == scl_pkg::CHAR_LF || rx == scl_pkg::CHAR_CR) begin
            if (line_len != 0) begin
                code = EVT_TEXT;
                for (int k = scl_pkg::NUM_CMDS - 1; k >= 0; k--) begin
                    if (cmd_mask[k] && word_pos == scl_pkg::CMD_LEN[k])
                        code = line_event_t'(k);
                end
                events_due.push_back(code);
                start_line();
            end
        end else if (line_len < LINE_KEEP) begin
            line_len++;
            if (rx == scl_pkg::CHAR_SPACE || rx == scl_pkg::CHAR_TAB
                    || rx == scl_pkg::CHAR_VT || rx == scl_pkg::CHAR_FF) begin
                if (phase == scl_pkg::PH_WORD)
                    phase = scl_pkg::PH_TAIL;
            end else begin
                // no command holds whitespace, so text after a gap matches nothing
                if (phase == scl_pkg::PH_TAIL)
                    cmd_mask = '0;
                phase = scl_pkg::PH_WORD;
                lc = (rx >= scl_pkg::CHAR_UC_A && rx <= scl_pkg::CHAR_UC_Z)
                   ? rx + scl_pkg::CASE_OFFSET : rx;
                still = '0;
                for (int k = 0; k < scl_pkg::NUM_CMDS; k++) begin
                    if (word_pos < scl_pkg::CMD_LEN[k] && scl_pkg::CMD_TEXT[k][word_pos] == lc)
                        still[k] = 1'b1;
                end
                cmd_mask = cmd_mask & still;
                if (word_pos != scl_pkg::POS_MAX)
                    word_pos = word_pos + 1'b1;
            end
        end
    endtask

    // request driver: predicts on acceptance, then offers the next byte or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            start_line();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                classify_byte(s_axis_tdata);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tdata  <= pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so the block backs up and stalls its input
    always @(posedge aclk) begin
        if (!hold_used && sent_cnt >= 400) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready with random stalls
    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge aclk) begin : result_check
        line_event_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (events_due.size() == 0) begin
                $error("event_code expected none got %0d", m_axis_tdata[2:0]);
                fails++;
            end else begin
                want = events_due.pop_front();
                if (m_axis_tdata[2:0] != want) begin
                    $error("event_code expected %0d got %0d", want, m_axis_tdata[2:0]);
                    fails++;
                end
                if (m_axis_tdata[7:3] != 5'd0) begin
                    $error("tdata pad expected 0 got %0d", m_axis_tdata[7:3]);
                    fails++;
                end
            end
        end
    end

    function automatic logic [7:0] any_blank();
        case ($urandom_range(3))
            0: return scl_pkg::CHAR_SPACE;
            1: return scl_pkg::CHAR_TAB;
            2: return scl_pkg::CHAR_VT;
            default: return scl_pkg::CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == scl_pkg::CHAR_LF || c == scl_pkg::CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1))
            return c - scl_pkg::CASE_OFFSET;
        return c;
    endfunction

    task automatic say(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endtask

    task automatic add_blanks(input int n);
        repeat (n) pending_bytes.push_back(any_blank());
    endtask

    task automatic end_line();
        case ($urandom_range(3))
            0: pending_bytes.push_back(scl_pkg::CHAR_CR);
            1: pending_bytes.push_back(scl_pkg::CHAR_LF);
            2: begin
                pending_bytes.push_back(scl_pkg::CHAR_CR);
                pending_bytes.push_back(scl_pkg::CHAR_LF);
            end
            default: begin
                pending_bytes.push_back(scl_pkg::CHAR_LF);
                pending_bytes.push_back(scl_pkg::CHAR_CR);
            end
        endcase
    endtask

    // a command word in random case, sometimes broken
    task automatic add_command(input int k, input bit mangle);
        logic [7:0] word[$];
        for (int i = 0; i < scl_pkg::CMD_LEN[k]; i++)
            word.push_back(scl_pkg::CMD_TEXT[k][i]);
        if (mangle) begin
            case ($urandom_range(3))
                0: void'(word.pop_back());
                1: word.push_back(8'(8'h61 + $urandom_range(25)));
                2: begin
                    word.push_back(any_blank());
                    word.push_back(8'(8'h61 + $urandom_range(25)));
                end
                default: word[$urandom_range(word.size() - 1)] = any_text_byte();
            endcase
        end
        foreach (word[i])
            pending_bytes.push_back(mixed_case(word[i]));
    endtask

    // stimulus, reset and final verdict
    initial begin
        int goal;
        int pick;
        int waited;

        // every command, case folding, trimming and the special lines
        say("w");
        pending_bytes.push_back(scl_pkg::CHAR_CR); pending_bytes.push_back(scl_pkg::CHAR_LF);
        pending_bytes.push_back(scl_pkg::CHAR_TAB); say("S");
        pending_bytes.push_back(scl_pkg::CHAR_LF);
        pending_bytes.push_back(scl_pkg::CHAR_VT); say("E");
        pending_bytes.push_back(scl_pkg::CHAR_FF);
        pending_bytes.push_back(scl_pkg::CHAR_CR);
        say("Q ");    pending_bytes.push_back(scl_pkg::CHAR_LF);
        say("WiFi");  pending_bytes.push_back(scl_pkg::CHAR_LF);
        say("cLeAr"); pending_bytes.push_back(scl_pkg::CHAR_CR);
        say("HeLP");  pending_bytes.push_back(scl_pkg::CHAR_LF);
        say(" ");     pending_bytes.push_back(scl_pkg::CHAR_CR);
        say("w e");   pending_bytes.push_back(scl_pkg::CHAR_LF);
        pending_bytes.push_back(8'h00); pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(scl_pkg::CHAR_LF);

        // random lines, mostly command words, some of them broken
        goal = pending_bytes.size() + RANDOM_ITEMS;
        while (pending_bytes.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                add_blanks($urandom_range(3));
                add_command($urandom_range(scl_pkg::NUM_CMDS - 1), $urandom_range(9) < 4);
                add_blanks($urandom_range(3));
                end_line();
            end else if (pick < 72) begin
                repeat ($urandom_range(8)) pending_bytes.push_back(any_text_byte());
                end_line();
            end else if (pick < 75) begin
                // overlong line, the cut falls around the word
                if ($urandom_range(1)) begin
                    add_blanks($urandom_range(LINE_KEEP - 6, LINE_KEEP + 1));
                    add_command($urandom_range(scl_pkg::NUM_CMDS - 1), 1'b0);
                end else begin
                    repeat ($urandom_range(LINE_KEEP - 3, LINE_KEEP + 12))
                        pending_bytes.push_back(any_text_byte());
                end
                end_line();
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(255)));
            end else begin
                add_blanks($urandom_range(3));
                end_line();
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // all bytes accepted, then all event codes back
        do @(negedge aclk); while (pending_bytes.size() != 0 || s_axis_tvalid);
        waited = 0;
        while (events_due.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (20) @(negedge aclk);
        if (events_due.size() != 0) begin
            $error("%0d event codes never arrived", events_due.size());
            fails++;
        end

        if (fails == 0) begin
            $display("serial_command_line_classifier verification clean");
        end else begin
            $display("serial_command_line_classifier verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("serial_command_line_classifier verification failed");
        $finish;
    end

endmodule
